// ----- rtl/core/cop_pkg.sv -----
// Shared types and constants for the cascaded one-pole lowpass filter bank.
`timescale 1ns / 1ps
`default_nettype none

package cop_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 18;
  localparam int LANE_BITS      = 2;
  localparam int CHANNEL_BITS   = 4;
  localparam int ORDER_BITS     = 3;

  typedef struct packed {
    logic [LANE_BITS-1:0]          lane;
    logic [CHANNEL_BITS-1:0]       channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [COEF_FRAC_BITS-1:0]     pole_coef;
  } cop_in_t;

  typedef struct packed {
    logic [LANE_BITS-1:0]          out_lane;
    logic [CHANNEL_BITS-1:0]       out_channel;
    logic signed [SAMPLE_BITS-1:0] sample_out;
  } cop_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } cop_state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic step;
    logic emit;
  } cop_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic run_last;
    logic in_range;
    logic out_free;
  } cop_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/cop_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cop_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 336,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cop_ctrl.sv -----
// Sequencing state machine for the filter bank: memory clear, accept, section run, result.
`timescale 1ns / 1ps
`default_nettype none

module cop_ctrl
  import cop_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cop_stat_t stat,
  output cop_cmd_t       cmd
);

  cop_state_t state;
  cop_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat.in_range) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
          if (stat.run_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/cop_dp.sv -----
// Datapath of the filter bank: section memory, one shared section unit and the result register.
`timescale 1ns / 1ps
`default_nettype none

module cop_dp
  import cop_pkg::*;
#(
  parameter int LANES     = 3,
  parameter int CHANNELS  = 16,
  parameter int MAX_POLES = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cop_cmd_t              cmd,
  output cop_stat_t                  stat,
  input  wire cop_in_t               in_data,
  input  wire logic                  cfg_we,
  input  wire logic [ORDER_BITS-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cop_out_t                   out_data
);

  localparam int DEPTH       = LANES * CHANNELS * MAX_POLES;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SEC_W       = $clog2(MAX_POLES + 1);
  localparam int LANE_STRIDE = CHANNELS * MAX_POLES;
  localparam int SB          = SAMPLE_BITS;
  localparam int CF          = COEF_FRAC_BITS;
  localparam int ACC_W       = SB + CF + 3;

  logic [ORDER_BITS-1:0]     filter_order;
  logic [SEC_W-1:0]          order_eff;
  logic [ADDR_W-1:0]         clr_addr;
  logic [ADDR_W-1:0]         base;
  logic [SEC_W-1:0]          cnt;
  logic                      in_range;
  logic [LANE_BITS-1:0]      lane;
  logic [CHANNEL_BITS-1:0]   channel;
  logic [CF-1:0]             coef;
  logic signed [SB-1:0]      x;
  logic signed [SB-1:0]      tap;

  logic [ADDR_W:0]           rd_sum;
  logic [ADDR_W:0]           wr_sum;
  logic                      rd_en;
  logic                      calc;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [SB-1:0]             ram_wdata;
  logic [SB-1:0]             ram_rdata;

  logic signed [SB-1:0]      mem_val;
  logic signed [SB:0]        diff;
  logic signed [CF+SB+1:0]   prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SB+2:0]      shifted;
  logic signed [SB-1:0]      y;

  always_comb begin
    if (filter_order == '0) begin
      order_eff = SEC_W'(1);
    end else if (int'(filter_order) > MAX_POLES) begin
      order_eff = SEC_W'(MAX_POLES);
    end else begin
      order_eff = SEC_W'(filter_order);
    end
  end

  assign rd_sum = {1'b0, base} + (ADDR_W + 1)'(cnt);
  assign wr_sum = rd_sum - (ADDR_W + 1)'(1);
  assign rd_en  = cmd.step && (int'(cnt) < MAX_POLES);
  assign calc   = cmd.step && (cnt != '0);

  assign mem_val = $signed(ram_rdata);
  assign diff    = {mem_val[SB-1], mem_val} - {x[SB-1], x};
  assign prod    = $signed({1'b0, coef}) * diff;
  assign acc     = $signed({{3{x[SB-1]}}, x, {CF{1'b0}}}) + $signed({prod[CF+SB+1], prod})
                 + $signed({{(ACC_W - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}});
  assign shifted = acc[ACC_W-1:CF];

  always_comb begin
    if (shifted[SB+2:SB-1] == '0 || shifted[SB+2:SB-1] == '1) begin
      y = shifted[SB-1:0];
    end else if (shifted[SB+2]) begin
      y = {1'b1, {(SB - 1){1'b0}}};
    end else begin
      y = {1'b0, {(SB - 1){1'b1}}};
    end
  end

  always_comb begin
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = calc;
      ram_waddr = wr_sum[ADDR_W-1:0];
      ram_wdata = y;
    end
  end

  cop_ram #(
    .WIDTH(SB),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(rd_sum[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= ORDER_BITS'(1);
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        filter_order <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lane     <= in_data.lane;
      channel  <= in_data.channel;
      coef     <= in_data.pole_coef;
      x        <= in_data.sample_in;
      tap      <= '0;
      cnt      <= '0;
      in_range <= (int'(in_data.lane) < LANES) && (int'(in_data.channel) < CHANNELS);
      base     <= ADDR_W'(int'(in_data.lane) * LANE_STRIDE
                          + int'(in_data.channel) * MAX_POLES);
    end else if (cmd.step) begin
      cnt <= cnt + SEC_W'(1);
      if (calc) begin
        x <= y;
        if (cnt == order_eff) begin
          tap <= y;
        end
      end
    end
    if (cmd.emit) begin
      out_data.out_lane    <= lane;
      out_data.out_channel <= channel;
      out_data.sample_out  <= tap;
    end
  end

  assign stat.clr_last = (int'(clr_addr) == DEPTH - 1);
  assign stat.run_last = (int'(cnt) == MAX_POLES);
  assign stat.in_range = in_range;
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- rtl/core/cascaded_one_pole_lowpass.sv -----
// Top level of the cascaded one-pole lowpass filter bank.
//
// Each transfer on the input channel carries one sample with its lane, channel and pole
// coefficient; the block runs it through MAX_POLES one-pole sections kept in a section
// memory and returns one result holding the output of the section chosen by filter_order,
// saturated to 24 bits. One shared multiply-accumulate unit works one section per cycle
// through a memory with a registered read; an item with an out-of-range lane or channel
// skips the sections and returns zero. The next item is taken while a result waits in the
// output register. After reset the section memory is cleared, one entry per cycle, over all
// LANES * CHANNELS * MAX_POLES entries (336 by default), during which no input transfer is
// taken; configuration writes are always taken and must only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_one_pole_lowpass
  import cop_pkg::*;
#(
  parameter int LANES     = 3,
  parameter int CHANNELS  = 16,
  parameter int MAX_POLES = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cop_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cop_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [ORDER_BITS-1:0] cfg_data
);

  cop_cmd_t  cmd;
  cop_stat_t stat;

  assign cfg_ready = 1'b1;

  cop_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  cop_dp #(
    .LANES    (LANES),
    .CHANNELS (CHANNELS),
    .MAX_POLES(MAX_POLES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/sv/cop_lowpass_tb_pkg.sv -----
// Scoreboard class and bit-accurate filter predictor for the cascaded one-pole lowpass bench.
`timescale 1ns / 1ps

package cop_lowpass_tb_pkg;

  import cop_pkg::*;

  localparam int NUM_LANES    = 3;
  localparam int NUM_CHANNELS = 16;
  localparam int NUM_SECTIONS = 7;

  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint COEF_ONE   = 64'sd1 <<< COEF_FRAC_BITS;
  localparam longint COEF_HALF  = 64'sd1 <<< (COEF_FRAC_BITS - 1);

  class lowpass_scoreboard;
    logic signed [SAMPLE_BITS-1:0] section_mem [NUM_LANES][NUM_CHANNELS][NUM_SECTIONS];
    logic [ORDER_BITS-1:0] order_reg;
    cop_out_t expected_q[$];
    int mismatches;
    int checked;

    function new();
      foreach (section_mem[l, c, s]) section_mem[l][c][s] = '0;
      order_reg = 1;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_order(input logic [ORDER_BITS-1:0] value);
      order_reg = value;
    endfunction

    // Runs one sample through all sections of its path and returns the tapped output.
    function cop_out_t filter_sample(input cop_in_t item);
      cop_out_t res;
      longint x;
      longint r;
      longint acc;
      longint y;
      int tap_pos;
      int s;
      res.out_lane = item.lane;
      res.out_channel = item.channel;
      res.sample_out = '0;
      tap_pos = (order_reg == 0) ? 1 : int'(order_reg);
      if (tap_pos > NUM_SECTIONS) begin
        tap_pos = NUM_SECTIONS;
      end
      if (item.lane < NUM_LANES && item.channel < NUM_CHANNELS) begin
        x = longint'(item.sample_in);
        r = longint'({1'b0, item.pole_coef});
        for (s = 0; s < NUM_SECTIONS; s++) begin
          acc = (COEF_ONE - r) * x
              + r * longint'(section_mem[item.lane][item.channel][s]) + COEF_HALF;
          y = acc >>> COEF_FRAC_BITS;
          if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
          end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
          end
          section_mem[item.lane][item.channel][s] = y[SAMPLE_BITS-1:0];
          x = y;
          if (s + 1 == tap_pos) begin
            res.sample_out = y[SAMPLE_BITS-1:0];
          end
        end
      end
      return res;
    endfunction

    function void note_sample(input cop_in_t item);
      expected_q.push_back(filter_sample(item));
    endfunction

    function void check_result(input cop_out_t got);
      cop_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        $error("Result transfer with nothing pending: lane %0d channel %0d sample %0d",
               got.out_lane, got.out_channel, got.sample_out);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_lane !== want.out_lane) begin
        $error("out_lane: expected %0d, got %0d", want.out_lane, got.out_lane);
        mismatches++;
      end
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
        mismatches++;
      end
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_cascaded_one_pole_lowpass.sv -----
// Top-level testbench for the cascaded one-pole lowpass filter bank.
`timescale 1ns / 1ps

module tb_cascaded_one_pole_lowpass;

  import cop_pkg::*;
  import cop_lowpass_tb_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 140;
  localparam int NUM_PHASES    = 8;
  localparam logic [LANE_BITS-1:0] UNUSED_LANE = 2'd3;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_POS_FULL = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG_FULL = 24'h800000;
  localparam logic [COEF_FRAC_BITS-1:0] POLE_FULL = 18'h3FFFF;
  localparam logic [COEF_FRAC_BITS-1:0] POLE_HALF = 18'h20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  cop_in_t in_data;
  logic out_valid;
  logic out_ready;
  cop_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [ORDER_BITS-1:0] cfg_data;

  lowpass_scoreboard sb;
  int in_idle_pct;
  int out_stall_pct;
  int quiet_cycles;
  int samples_taken;
  int unused_lane_taken;
  logic [LANE_BITS-1:0] hot_lane;
  logic [CHANNEL_BITS-1:0] hot_channel;
  logic [ORDER_BITS-1:0] phase_orders [NUM_PHASES] = '{3'd7, 3'd1, 3'd0, 3'd4,
                                                       3'd2, 3'd6, 3'd3, 3'd5};

  cascaded_one_pole_lowpass dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if (in_valid && in_ready) begin
        sb.note_sample(in_data);
        samples_taken <= samples_taken + 1;
        if (in_data.lane == UNUSED_LANE) begin
          unused_lane_taken <= unused_lane_taken + 1;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // The ready signal is sampled in mid-cycle, where it is stable until the next rising edge.
  task automatic send_item(input cop_in_t d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_fields(input logic [LANE_BITS-1:0] lane,
                             input logic [CHANNEL_BITS-1:0] channel,
                             input logic [SAMPLE_BITS-1:0] sample,
                             input logic [COEF_FRAC_BITS-1:0] pole);
    cop_in_t d;
    d.lane = lane;
    d.channel = channel;
    d.sample_in = sample;
    d.pole_coef = pole;
    send_item(d);
  endtask

  task automatic write_order(input logic [ORDER_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_order(value);
  endtask

  task automatic drain(input int settle);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // About half of the traffic goes to one path so that its sections build up history.
  function automatic cop_in_t random_item();
    cop_in_t d;
    logic [31:0] bits;
    bits = $urandom();
    if ($urandom_range(99) < 4) begin
      d.lane = UNUSED_LANE;
      d.channel = bits[CHANNEL_BITS-1:0];
    end else if ($urandom_range(1) == 0) begin
      d.lane = hot_lane;
      d.channel = hot_channel;
    end else begin
      d.lane = LANE_BITS'($urandom_range(NUM_LANES - 1));
      d.channel = bits[CHANNEL_BITS-1:0];
    end
    bits = $urandom();
    case ($urandom_range(7))
      0: d.sample_in = SAMPLE_POS_FULL;
      1: d.sample_in = SAMPLE_NEG_FULL;
      2: d.sample_in = SAMPLE_BITS'(int'($urandom_range(511)) - 256);
      3: d.sample_in = '0;
      default: d.sample_in = bits[SAMPLE_BITS-1:0];
    endcase
    bits = $urandom();
    case ($urandom_range(5))
      0: d.pole_coef = '0;
      1: d.pole_coef = POLE_FULL;
      2: d.pole_coef = POLE_FULL - COEF_FRAC_BITS'($urandom_range(4095));
      default: d.pole_coef = bits[COEF_FRAC_BITS-1:0];
    endcase
    return d;
  endfunction

  initial begin
    int p;
    int n;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    quiet_cycles = 0;
    samples_taken = 0;
    unused_lane_taken = 0;
    hot_lane = '0;
    hot_channel = '0;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_order(3'd7);
    send_fields(2'd0, 4'd0, '0, '0);
    send_fields(2'd0, 4'd0, SAMPLE_POS_FULL, '0);
    send_fields(2'd0, 4'd0, SAMPLE_NEG_FULL, '0);
    repeat (4) send_fields(2'd1, 4'd5, SAMPLE_POS_FULL, POLE_FULL);
    send_fields(2'd1, 4'd5, SAMPLE_NEG_FULL, POLE_FULL);
    repeat (4) send_fields(2'd2, 4'd15, SAMPLE_POS_FULL, POLE_HALF);
    repeat (2) send_fields(2'd2, 4'd15, SAMPLE_NEG_FULL, POLE_HALF);
    send_fields(UNUSED_LANE, 4'd15, SAMPLE_POS_FULL, POLE_FULL);
    send_fields(UNUSED_LANE, 4'd0, SAMPLE_NEG_FULL, '0);
    send_fields(2'd0, 4'd15, 24'hFFFFFF, 18'd1);
    send_fields(2'd0, 4'd15, 24'h000001, POLE_FULL);
    send_fields(2'd1, 4'd0, SAMPLE_POS_FULL, POLE_FULL - 18'd1);
    send_fields(2'd2, 4'd7, 24'h555555, 18'h2AAAA);
    send_fields(2'd2, 4'd7, 24'h2AAAAA, 18'h15555);
    in_valid <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      drain(12);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 59; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 59; end
        default: begin in_idle_pct = 17; out_stall_pct = 17; end
      endcase
      write_order(phase_orders[p]);
      hot_lane = LANE_BITS'($urandom_range(NUM_LANES - 1));
      hot_channel = CHANNEL_BITS'($urandom_range(NUM_CHANNELS - 1));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item());
      end
      in_valid <= 1'b0;
    end

    drain(20);
    $display("Sent %0d samples (%0d on the unused lane) across eight filter orders,",
             samples_taken, unused_lane_taken);
    $display("with four pacing mixes; %0d results checked, %0d mismatches.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
